>>> design/gbfo_pkg.sv
// Package for the graph breadth-first order unit.
// Holds the fixed field widths and the item mode codes; no dependencies.
`default_nettype none

package gbfo_pkg;

    localparam int MODE_W  = 2;
    localparam int LABEL_W = 8;
    localparam int INDEX_W = 6;

    typedef enum logic [MODE_W-1:0] {
        MODE_VERTEX = 2'd0,
        MODE_EDGE   = 2'd1,
        MODE_RUN    = 2'd2
    } mode_t;

endpackage

`default_nettype wire

>>> design/gbfo_queue.sv
// Pending-vertex queue for the breadth-first walk: one memory, head and tail pointers.
// Depends on gbfo_pkg for the vertex index width.
`default_nettype none

module gbfo_queue #(
    parameter int DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clear,
    input  wire logic                        push,
    input  wire logic [gbfo_pkg::INDEX_W-1:0] push_data,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [gbfo_pkg::INDEX_W-1:0]     rd_data
);
    import gbfo_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);

    logic [INDEX_W-1:0] q_mem [DEPTH];
    logic [PW-1:0]      head_reg;
    logic [PW-1:0]      tail_reg;

    assign empty = (head_reg == tail_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (clear)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= tail_reg + PW'(1);
            if (pop)
                head_reg <= head_reg + PW'(1);
        end
    end

    // entry store with registered read at the head
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[tail_reg[IW-1:0]] <= push_data;
        rd_data <= q_mem[head_reg[IW-1:0]];
    end

endmodule

`default_nettype wire

>>> design/graph_breadth_first_order_unit.sv
// Graph breadth-first order unit: loads an undirected graph and emits its BFS order.
// Depends on gbfo_pkg and instantiates gbfo_queue.
//
// Each input request carries a mode. Mode 0 appends a vertex with an 8-bit label
// (ignored once MAX_VERTICES vertices exist). Mode 1 adds an undirected edge
// end_a--end_b; an edge with an endpoint not yet loaded, or that would overflow
// either adjacency list (a self-loop needs two free slots), is dropped and the
// sticky edges_dropped flag is set until reset. Mode 2 runs a traversal: every
// visited mark is cleared, then each unvisited vertex in index order seeds a
// breadth-first walk whose neighbours are scanned newest first. One result
// request leaves per dequeued vertex, so a run yields exactly one result per
// loaded vertex; last_visit marks the final one and an empty graph yields none.
// Mode 3 is ignored. The unit handles one request at a time and in_ready is low
// while it works. An edge request ends early when an endpoint is out of range,
// later when a list is full, and runs on to write both lists when the edge is
// stored. A run also waits whenever the consumer holds out_ready low; its pace
// is set by the single read port of the neighbour store, read once per adjacency
// entry, and by the registered reads of the queue and label memory.
`default_nettype none

module graph_breadth_first_order_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DEGREE   = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [gbfo_pkg::MODE_W-1:0]  mode,
    input  wire logic [gbfo_pkg::LABEL_W-1:0] label,
    input  wire logic [gbfo_pkg::INDEX_W-1:0] end_a,
    input  wire logic [gbfo_pkg::INDEX_W-1:0] end_b,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [gbfo_pkg::LABEL_W-1:0]      visit_label,
    output logic [gbfo_pkg::INDEX_W-1:0]      visit_index,
    output logic                              last_visit,
    output logic                              edges_dropped
);
    import gbfo_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int DW     = $clog2(MAX_DEGREE + 1);
    localparam int NDEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int NAW    = $clog2(NDEPTH);
    localparam int XW     = INDEX_W + 1;

    localparam logic [DW:0]  DEG_LIM = (DW+1)'(MAX_DEGREE);
    localparam logic [CW-1:0] V_LIM  = CW'(MAX_VERTICES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VTX,
        ST_E_RDA,
        ST_E_RDB,
        ST_E_CHK,
        ST_E_WRB,
        ST_R_INIT,
        ST_R_START,
        ST_R_DEQ,
        ST_R_VRD,
        ST_R_LOAD,
        ST_R_EMIT,
        ST_R_NBR,
        ST_R_NBW
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          total_reg;
    logic                   drop_reg;
    logic [LABEL_W-1:0]     label_reg;
    logic [INDEX_W-1:0]     a_reg;
    logic [INDEX_W-1:0]     b_reg;
    logic [DW-1:0]          cnt_a_reg;
    logic [DW-1:0]          cnt_b_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [CW-1:0]          seed_reg;
    logic [CW-1:0]          emit_cnt_reg;
    logic [VW-1:0]          v_reg;
    logic [DW-1:0]          k_reg;
    logic                   out_valid_reg;
    logic [LABEL_W-1:0]     visit_label_reg;
    logic [INDEX_W-1:0]     visit_index_reg;
    logic                   last_visit_reg;
    logic                   edges_dropped_reg;

    // Memories
    logic [LABEL_W-1:0] lbl_mem [MAX_VERTICES];
    logic [DW-1:0]      cnt_mem [MAX_VERTICES];
    logic [VW-1:0]      nbr_mem [NDEPTH];

    logic               lbl_we;
    logic [VW-1:0]      lbl_raddr;
    logic [LABEL_W-1:0] lbl_rdata;
    logic               cnt_we;
    logic [VW-1:0]      cnt_waddr;
    logic [DW-1:0]      cnt_wdata;
    logic [VW-1:0]      cnt_raddr;
    logic [DW-1:0]      cnt_rdata;
    logic               nbr_we;
    logic [NAW-1:0]     nbr_waddr;
    logic [VW-1:0]      nbr_wdata;
    logic [NAW-1:0]     nbr_raddr;
    logic [VW-1:0]      nbr_rdata;

    // Queue
    logic               q_clear;
    logic               q_push;
    logic [INDEX_W-1:0] q_push_data;
    logic               q_pop;
    logic               q_empty;
    logic [INDEX_W-1:0] q_rd_data;

    // Edge checks
    logic               a_out;
    logic               b_out;
    logic               self_loop;
    logic [DW:0]        need_a_sum;
    logic [DW:0]        need_b_sum;
    logic               list_full;
    logic [VW-1:0]      a_idx;
    logic [VW-1:0]      b_idx;
    logic               seed_seen;
    logic               nbr_seen;
    logic               vtx_room;

    assign a_idx     = a_reg[VW-1:0];
    assign b_idx     = b_reg[VW-1:0];
    assign a_out     = (XW'(a_reg) >= XW'(total_reg));
    assign b_out     = (XW'(b_reg) >= XW'(total_reg));
    assign self_loop = (a_reg == b_reg);
    // cnt_rdata carries b's count in the check state
    assign need_a_sum = (DW+1)'(cnt_a_reg) + (self_loop ? (DW+1)'(2) : (DW+1)'(1));
    assign need_b_sum = (DW+1)'(cnt_rdata) + (DW+1)'(1);
    assign list_full  = (need_a_sum > DEG_LIM) || (need_b_sum > DEG_LIM);
    assign seed_seen  = visited_reg[seed_reg[VW-1:0]];
    assign nbr_seen   = visited_reg[nbr_rdata];
    assign vtx_room   = (total_reg < V_LIM);

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign visit_label   = visit_label_reg;
    assign visit_index   = visit_index_reg;
    assign last_visit    = last_visit_reg;
    assign edges_dropped = edges_dropped_reg;

    // Memory and queue controls, decoded from the sequencer state
    always_comb
    begin
        lbl_we      = 1'b0;
        lbl_raddr   = q_rd_data[VW-1:0];
        cnt_we      = 1'b0;
        cnt_waddr   = total_reg[VW-1:0];
        cnt_wdata   = '0;
        cnt_raddr   = q_rd_data[VW-1:0];
        nbr_we      = 1'b0;
        nbr_waddr   = NAW'(a_idx) * NAW'(MAX_DEGREE) + NAW'(cnt_a_reg);
        nbr_wdata   = b_idx;
        nbr_raddr   = NAW'(v_reg) * NAW'(MAX_DEGREE) + NAW'(k_reg - DW'(1));
        q_clear     = 1'b0;
        q_push      = 1'b0;
        q_push_data = INDEX_W'(seed_reg[VW-1:0]);
        q_pop       = 1'b0;
        case (state_reg)
            ST_VTX:
            begin
                // new vertex: store its label and zero its list length
                lbl_we = vtx_room;
                cnt_we = vtx_room;
            end
            ST_E_RDA:
                cnt_raddr = a_idx;
            ST_E_RDB:
                cnt_raddr = b_idx;
            ST_E_CHK:
            begin
                nbr_we    = !list_full;
                cnt_we    = !list_full;
                cnt_waddr = a_idx;
                cnt_wdata = cnt_a_reg + DW'(1);
            end
            ST_E_WRB:
            begin
                nbr_we    = 1'b1;
                nbr_waddr = NAW'(b_idx) * NAW'(MAX_DEGREE) + NAW'(cnt_b_reg);
                nbr_wdata = a_idx;
                cnt_we    = 1'b1;
                cnt_waddr = b_idx;
                cnt_wdata = cnt_b_reg + DW'(1);
            end
            ST_R_INIT:
                q_clear = 1'b1;
            ST_R_START:
                q_push = (seed_reg != total_reg) && !seed_seen;
            ST_R_DEQ:
                q_pop = !q_empty;
            ST_R_NBW:
            begin
                q_push      = !nbr_seen;
                q_push_data = INDEX_W'(nbr_rdata);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl_mem[total_reg[VW-1:0]] <= label_reg;
        lbl_rdata <= lbl_mem[lbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we)
            nbr_mem[nbr_waddr] <= nbr_wdata;
        nbr_rdata <= nbr_mem[nbr_raddr];
    end

    gbfo_queue #(
        .DEPTH (MAX_VERTICES)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (q_clear),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .empty     (q_empty),
        .rd_data   (q_rd_data)
    );

    // Sequencer: state plus registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            drop_reg      <= 1'b0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        label_reg <= label;
                        a_reg     <= end_a;
                        b_reg     <= end_b;
                        case (mode_t'(mode))
                            MODE_VERTEX: state_reg <= ST_VTX;
                            MODE_EDGE:   state_reg <= ST_E_RDA;
                            MODE_RUN:    state_reg <= ST_R_INIT;
                            default:     state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_VTX:
                begin
                    if (vtx_room)
                        total_reg <= total_reg + CW'(1);
                    state_reg <= ST_IDLE;
                end
                ST_E_RDA:
                begin
                    // drop an edge that names a vertex not loaded yet
                    if (a_out || b_out)
                    begin
                        drop_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_E_RDB;
                end
                ST_E_RDB:
                begin
                    cnt_a_reg <= cnt_rdata;
                    state_reg <= ST_E_CHK;
                end
                ST_E_CHK:
                begin
                    if (list_full)
                    begin
                        drop_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        // a self-loop takes the slot right after the one just written
                        cnt_b_reg <= self_loop ? (cnt_a_reg + DW'(1)) : cnt_rdata;
                        state_reg <= ST_E_WRB;
                    end
                end
                ST_E_WRB:
                    state_reg <= ST_IDLE;
                ST_R_INIT:
                begin
                    visited_reg  <= '0;
                    seed_reg     <= '0;
                    emit_cnt_reg <= '0;
                    state_reg    <= ST_R_START;
                end
                ST_R_START:
                begin
                    if (seed_reg == total_reg)
                        state_reg <= ST_IDLE;
                    else if (seed_seen)
                        seed_reg <= seed_reg + CW'(1);
                    else
                    begin
                        visited_reg[seed_reg[VW-1:0]] <= 1'b1;
                        state_reg <= ST_R_DEQ;
                    end
                end
                ST_R_DEQ:
                begin
                    // queue drained: move on to the next seed
                    if (q_empty)
                    begin
                        seed_reg  <= seed_reg + CW'(1);
                        state_reg <= ST_R_START;
                    end
                    else
                        state_reg <= ST_R_VRD;
                end
                ST_R_VRD:
                begin
                    v_reg     <= q_rd_data[VW-1:0];
                    state_reg <= ST_R_LOAD;
                end
                ST_R_LOAD:
                begin
                    visit_label_reg   <= lbl_rdata;
                    visit_index_reg   <= INDEX_W'(v_reg);
                    last_visit_reg    <= (emit_cnt_reg == total_reg - CW'(1));
                    edges_dropped_reg <= drop_reg;
                    out_valid_reg     <= 1'b1;
                    k_reg             <= cnt_rdata;
                    emit_cnt_reg      <= emit_cnt_reg + CW'(1);
                    state_reg         <= ST_R_EMIT;
                end
                ST_R_EMIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_R_NBR;
                    end
                end
                ST_R_NBR:
                begin
                    // scan the list newest entry first
                    if (k_reg == '0)
                        state_reg <= ST_R_DEQ;
                    else
                    begin
                        k_reg     <= k_reg - DW'(1);
                        state_reg <= ST_R_NBW;
                    end
                end
                ST_R_NBW:
                begin
                    if (!nbr_seen)
                        visited_reg[nbr_rdata] <= 1'b1;
                    state_reg <= ST_R_NBR;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_breadth_first_order_unit.
// Loads vertices and edges, runs traversals and checks each visit against a BFS of the same graph.
// Depends on gbfo_pkg and the unit's RTL only.

module tb_top;
    import gbfo_pkg::*;

    localparam int VERTEX_CAP    = 64;
    localparam int DEGREE_CAP    = 64;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [INDEX_W-1:0] HUB = '0;
    localparam int IDLE_PCT      = 32;
    localparam int WORK_TARGET   = 250;
    localparam int HOLD_AT       = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 40000;

    // One visit as the unit reports it.
    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               dropped;
    } visit_t;

    // Mirror of the graph store; a run request expands into the visits it must produce.
    class visit_order_board;
        logic [LABEL_W-1:0] labels [VERTEX_CAP];
        logic [INDEX_W-1:0] adj [VERTEX_CAP*DEGREE_CAP];
        int unsigned        degree [VERTEX_CAP];
        int unsigned        vertex_count;
        bit                 dropped;
        visit_t             due_visits [$];
        int                 errors;
        int                 checked;
        int                 runs;

        function void note_request(logic [MODE_W-1:0] m, logic [LABEL_W-1:0] lab,
                                   logic [INDEX_W-1:0] a, logic [INDEX_W-1:0] b);
            bit                 seen [VERTEX_CAP];
            logic [INDEX_W-1:0] order [$];
            logic [INDEX_W-1:0] v;
            logic [INDEX_W-1:0] w;
            int unsigned        need_a;
            int                 first;
            visit_t             step_visit;
            case (m)
                MODE_VERTEX:
                    if (vertex_count < VERTEX_CAP) begin
                        labels[vertex_count] = lab;
                        degree[vertex_count] = 0;
                        vertex_count++;
                    end
                MODE_EDGE: begin
                    // a self-loop lands twice in the same list
                    need_a = (a == b) ? 2 : 1;
                    if (a >= vertex_count || b >= vertex_count ||
                        degree[a] + need_a > DEGREE_CAP || degree[b] + 1 > DEGREE_CAP)
                        dropped = 1'b1;
                    else begin
                        adj[a*DEGREE_CAP + degree[a]] = b;
                        degree[a]++;
                        adj[b*DEGREE_CAP + degree[b]] = a;
                        degree[b]++;
                    end
                end
                MODE_RUN: begin
                    runs++;
                    first = due_visits.size();
                    seen = '{default: 1'b0};
                    for (int s = 0; s < vertex_count; s++) begin
                        if (!seen[s]) begin
                            seen[s] = 1'b1;
                            order.push_back(INDEX_W'(s));
                            while (order.size() > 0) begin
                                v = order.pop_front();
                                step_visit.label   = labels[v];
                                step_visit.index   = v;
                                step_visit.last    = 1'b0;
                                step_visit.dropped = dropped;
                                due_visits.push_back(step_visit);
                                // newest neighbour first
                                for (int k = int'(degree[v]) - 1; k >= 0; k--) begin
                                    w = adj[v*DEGREE_CAP + k];
                                    if (!seen[w]) begin
                                        seen[w] = 1'b1;
                                        order.push_back(w);
                                    end
                                end
                            end
                        end
                    end
                    if (due_visits.size() > first) begin
                        step_visit = due_visits.pop_back();
                        step_visit.last = 1'b1;
                        due_visits.push_back(step_visit);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_visit(visit_t got);
            visit_t want;
            if (due_visits.size() == 0) begin
                errors++;
                $display("%0t: unexpected visit: index %0d label %0h last %0b dropped %0b",
                         $time, got.index, got.label, got.last, got.dropped);
                return;
            end
            want = due_visits.pop_front();
            checked++;
            if (got.label !== want.label || got.index !== want.index ||
                got.last !== want.last || got.dropped !== want.dropped) begin
                errors++;
                $display({"%0t: visit mismatch: expected label %0h index %0d last %0b ",
                          "dropped %0b, actual label %0h index %0d last %0b dropped %0b"},
                         $time, want.label, want.index, want.last, want.dropped,
                         got.label, got.index, got.last, got.dropped);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  mode = '0;
    logic [LABEL_W-1:0] label = '0;
    logic [INDEX_W-1:0] end_a = '0;
    logic [INDEX_W-1:0] end_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [LABEL_W-1:0] visit_label;
    logic [INDEX_W-1:0] visit_index;
    logic               last_visit;
    logic               edges_dropped;

    bit                 calm = 1'b0;     // suppress idling on both sides
    int                 work_items = 0;  // requests that change state or produce visits
    int                 visits_taken = 0;
    int                 stall_cycles = 0;
    visit_order_board   board = new;

    graph_breadth_first_order_unit #(
        .MAX_VERTICES(VERTEX_CAP),
        .MAX_DEGREE  (DEGREE_CAP)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .label        (label),
        .end_a        (end_a),
        .end_b        (end_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .visit_label  (visit_label),
        .visit_index  (visit_index),
        .last_visit   (last_visit),
        .edges_dropped(edges_dropped)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one request, idling first at random; hold it until the unit takes it.
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [LABEL_W-1:0] lab,
                                input logic [INDEX_W-1:0] a, input logic [INDEX_W-1:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        label    <= lab;
        end_a    <= a;
        end_b    <= b;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (m != MODE_SPARE && !(m == MODE_VERTEX && board.vertex_count >= VERTEX_CAP))
            work_items++;
        board.note_request(m, lab, a, b);
    endtask

    task automatic send_vertex(input logic [LABEL_W-1:0] lab);
        send_request(MODE_VERTEX, lab, INDEX_W'($urandom), INDEX_W'($urandom));
    endtask

    task automatic send_edge(input logic [INDEX_W-1:0] a, input logic [INDEX_W-1:0] b);
        send_request(MODE_EDGE, LABEL_W'($urandom), a, b);
    endtask

    task automatic send_run();
        send_request(MODE_RUN, LABEL_W'($urandom), INDEX_W'($urandom), INDEX_W'($urandom));
    endtask

    // Drop valid, wait for every outstanding visit, then let the unit settle.
    task automatic await_drain();
        in_valid <= 1'b0;
        while (board.due_visits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                 pick;
        int                 phase;
        logic [INDEX_W-1:0] x;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-graph run, spare mode, label and index extremes,
        // a self-loop, repeated runs, then out-of-range edges to raise the sticky flag.
        send_run();
        send_request(MODE_SPARE, '1, '1, '1);
        send_vertex('0);
        send_vertex('1);
        send_vertex(8'h5A);
        send_edge(6'd0, 6'd1);
        send_edge(6'd2, 6'd2);
        send_edge(6'd1, 6'd2);
        send_run();
        send_run();
        send_edge(6'd0, 6'd63);
        send_edge(6'd63, 6'd0);
        send_run();
        send_request(MODE_SPARE, LABEL_W'($urandom), INDEX_W'($urandom), INDEX_W'($urandom));

        // Random phases: grow the graph, add edges, finish each phase with a run.
        phase = 0;
        while (work_items < WORK_TARGET)
        begin
            calm = (phase == 4 || phase == 5);
            if (phase == 3)
                await_drain();
            repeat ($urandom_range(8, 3)) send_vertex(LABEL_W'($urandom));
            if (phase == 1)
            begin
                // Fill the hub's list to the brim; at one free slot a self-loop must be refused.
                while (board.degree[HUB] < DEGREE_CAP)
                begin
                    x = INDEX_W'($urandom_range(board.vertex_count - 1, 1));
                    if (board.degree[HUB] == DEGREE_CAP - 1)
                    begin
                        send_edge(HUB, HUB);
                        send_edge(HUB, x);
                    end
                    else if (board.degree[HUB] < DEGREE_CAP - 2 && $urandom_range(9) == 0)
                        send_edge(HUB, HUB);
                    else if ($urandom_range(1))
                        send_edge(HUB, x);
                    else
                        send_edge(x, HUB);
                end
                // full list on either side of the edge
                send_edge(x, HUB);
                send_edge(HUB, x);
            end
            else
            begin
                repeat ($urandom_range(14, 4))
                begin
                    pick = $urandom_range(99);
                    x = INDEX_W'($urandom_range(board.vertex_count - 1));
                    if (pick < 75)
                        send_edge(x, INDEX_W'($urandom_range(board.vertex_count - 1)));
                    else if (pick < 85)
                        send_edge(x, x);
                    else
                        send_edge(INDEX_W'($urandom), INDEX_W'($urandom));
                end
                if ($urandom_range(9) == 0)
                    send_request(MODE_SPARE, LABEL_W'($urandom), INDEX_W'($urandom),
                                 INDEX_W'($urandom));
            end
            send_run();
            phase++;
        end
        calm = 1'b0;

        // Top up the vertex store, push one more vertex past capacity, run once more.
        while (board.vertex_count < VERTEX_CAP)
            send_vertex(LABEL_W'($urandom));
        send_vertex(LABEL_W'($urandom));
        send_edge(INDEX_W'($urandom), INDEX_W'($urandom));
        send_run();
        await_drain();

        $display("summary: %0d traversals, %0d visits checked, %0d vertices, drop flag %0b",
                 board.runs, board.checked, board.vertex_count, board.dropped);
        $display("summary: %0d mismatches", board.errors);
        if (board.errors == 0 && board.due_visits.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Result side: check each accepted visit, idle at random, and once hold off
    // long enough that the unit backs up and the sender waits on in_ready.
    initial
    begin : visit_sink
        bit     held;
        visit_t got;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                got.label   = visit_label;
                got.index   = visit_index;
                got.last    = last_visit;
                got.dropped = edges_dropped;
                board.check_visit(got);
                visits_taken++;
            end
            if (visits_taken == HOLD_AT && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

endmodule
